// ===== sv/swts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swts_pkg;

	// Table geometry
	localparam int DEPTH      = 65536;
	localparam int WORD_BYTES = 24;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int COUNT_W    = ADDR_W + 1;
	localparam int CFG_W      = 17;
	localparam int INDEX_W    = 16;
	localparam int POS_W      = 16;
	localparam int LANE_W     = 64;
	localparam int WORD_W     = 3 * LANE_W;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic write_mem;
		logic issue_read;
		logic step;
		logic load_out;
	} swts_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_load;
		logic empty;
		logic match;
		logic out_free;
	} swts_status_t;

endpackage

`default_nettype wire

// ===== sv/swts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swts_ctrl
	import swts_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  swts_status_t      status,
	output swts_cmd_t         cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_CHECK,
		S_CMP,
		S_DONE
	} state_t;

	state_t state_q;

	// Decode commands from the current state
	always_comb begin
		cmd            = '0;
		cmd.capture    = (state_q == S_IDLE) && in_valid;
		cmd.write_mem  = (state_q == S_LOAD);
		cmd.issue_read = (state_q == S_CHECK) && !status.empty;
		cmd.step       = (state_q == S_CMP);
		cmd.load_out   = (state_q == S_DONE) && status.out_free;
	end

	assign in_stall = (state_q != S_IDLE);

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= status.is_load ? S_LOAD : S_CHECK;
					end
				end
				S_LOAD: begin
					state_q <= S_IDLE;
				end
				S_CHECK: begin
					state_q <= status.empty ? S_DONE : S_CMP;
				end
				S_CMP: begin
					state_q <= status.match ? S_DONE : S_CHECK;
				end
				S_DONE: begin
					if (status.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/swts_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swts_datapath
	import swts_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                mode,
	input  wire logic [INDEX_W-1:0]  entry_index,
	input  wire logic [LANE_W-1:0]   chars_low,
	input  wire logic [LANE_W-1:0]   chars_mid,
	input  wire logic [LANE_W-1:0]   chars_high,
	input  wire logic                cfg_write,
	input  wire logic [CFG_W-1:0]    cfg_data,
	input  wire logic                out_stall,
	output logic                     out_valid,
	output logic                     found,
	output logic [POS_W-1:0]         position,
	input  swts_cmd_t                cmd,
	output swts_status_t             status
);

	// Clear every byte after the first zero byte and beyond the word length
	function automatic logic [WORD_W-1:0] normalize(input logic [WORD_W-1:0] raw);
		logic [WORD_W-1:0] res;
		logic [23:0]       zero;
		logic              kill;
		int                i;
		int                j;
		res = raw;
		for (i = 0; i < 24; i++) begin
			zero[i] = (raw[WORD_W-1-8*i -: 8] == 8'd0);
		end
		for (i = 0; i < 24; i++) begin
			kill = (i >= WORD_BYTES);
			for (j = 0; j < i; j++) begin
				kill = kill | zero[j];
			end
			if (kill) begin
				res[WORD_W-1-8*i -: 8] = 8'd0;
			end
		end
		return res;
	endfunction

	logic [WORD_W-1:0]  table_q [DEPTH];
	logic [WORD_W-1:0]  key_q;
	logic [WORD_W-1:0]  entry_q;
	logic [ADDR_W-1:0]  idx_q;
	logic               idx_ok_q;
	logic               mode_q;
	logic [CFG_W-1:0]   word_count_q;
	logic [COUNT_W-1:0] lo_q;
	logic [COUNT_W-1:0] hi_excl_q;
	logic [ADDR_W-1:0]  mid_q;
	logic               hit_q;
	logic               out_valid_q;
	logic               found_q;
	logic [POS_W-1:0]   position_q;

	logic [COUNT_W-1:0] count_sat;
	logic [COUNT_W-1:0] mid_sum;
	logic [ADDR_W-1:0]  mid;
	logic               key_lt;
	logic               key_eq;

	// Saturate the entry count to the table depth
	assign count_sat = ({{(32-CFG_W){1'b0}}, word_count_q} > 32'(DEPTH)) ?
		COUNT_W'(DEPTH) : COUNT_W'(word_count_q);

	// Probe point: floor of (lo + hi) / 2 with hi inclusive
	assign mid_sum = lo_q + hi_excl_q - COUNT_W'(1);
	assign mid     = mid_sum[COUNT_W-1:1];

	// One wide unsigned compare; byte 0 is most significant
	assign key_lt = (key_q < entry_q);
	assign key_eq = (key_q == entry_q);

	assign status.is_load  = !mode;
	assign status.empty    = (lo_q >= hi_excl_q);
	assign status.match    = key_eq;
	assign status.out_free = !out_valid_q || !out_stall;

	// Hold the count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= '0;
		end else if (cfg_write) begin
			word_count_q <= cfg_data;
		end
	end

	// Capture the beat and run the search bounds
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q     <= normalize({chars_low, chars_mid, chars_high});
			idx_q     <= ADDR_W'(entry_index);
			idx_ok_q  <= ({{(32-INDEX_W){1'b0}}, entry_index} < 32'(DEPTH));
			mode_q    <= mode;
			lo_q      <= '0;
			hi_excl_q <= count_sat;
			hit_q     <= 1'b0;
		end
		if (cmd.issue_read) begin
			mid_q <= mid;
		end
		if (cmd.step) begin
			if (key_eq) begin
				hit_q <= 1'b1;
			end else if (key_lt) begin
				hi_excl_q <= COUNT_W'(mid_q);
			end else begin
				lo_q <= COUNT_W'(mid_q) + COUNT_W'(1);
			end
		end
	end

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.write_mem && idx_ok_q && !mode_q) begin
			table_q[idx_q] <= key_q;
		end
		if (cmd.issue_read) begin
			entry_q <= table_q[mid];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			found_q    <= hit_q;
			position_q <= hit_q ? POS_W'(mid_q) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign position  = position_q;

endmodule

`default_nettype wire

// ===== sv/sorted_word_table_search_top.sv =====
// Sorted word table search. Load beats (mode 0) write one normalized word of up
// to 24 bytes into the table at entry_index and give no result. Search beats
// (mode 1) binary-search entries 0 to word_count-1 and give one result with
// found and position (position 0 when not found). A search stops at the first
// probe that matches, makes at most 17 probes for 65536 entries and may wait on
// out_stall before its result is loaded; each probe is one registered read of
// the table memory followed by one 192-bit compare. Entries must be loaded in
// ascending order and written before they are searched; the table is not
// cleared at reset. word_count is written through cfg_write and cfg_data; the
// user must write it only while the block is idle, which the block itself does
// not enforce. A finished result waits in an output register while the next
// beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module sorted_word_table_search_top
	import swts_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                mode,
	input  wire logic [INDEX_W-1:0]  entry_index,
	input  wire logic [LANE_W-1:0]   chars_low,
	input  wire logic [LANE_W-1:0]   chars_mid,
	input  wire logic [LANE_W-1:0]   chars_high,
	input  wire logic                cfg_write,
	input  wire logic [CFG_W-1:0]    cfg_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     found,
	output logic [POS_W-1:0]         position
);

	swts_cmd_t    cmd;
	swts_status_t status;

	// Sequencer
	swts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Table, bounds and output register
	swts_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode),
		.entry_index (entry_index),
		.chars_low   (chars_low),
		.chars_mid   (chars_mid),
		.chars_high  (chars_high),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.found       (found),
		.position    (position),
		.cmd         (cmd),
		.status      (status)
	);

endmodule

`default_nettype wire

// ===== sv/swts_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swts_checker
	import swts_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic                mode,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire logic                found,
	input wire logic [POS_W-1:0]    position
);

	// A taken beat keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after a beat");

	// A miss always reports position zero
	a_miss_position: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (position == '0))
		else $error("miss with nonzero position");

	// A load beat never raises a result in the next cycle
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !mode) |=> !$rose(out_valid))
		else $error("result raised by a load beat");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(found) && $stable(position)))
		else $error("stalled result changed");

endmodule

bind sorted_word_table_search_top swts_checker u_swts_checker (.*);

`default_nettype wire
